[rtl/lpc_pkg.sv]
// Shared types and constants of the lifecycle precedence counter.
package lpc_pkg;

  // Fixed field widths of the transfer payloads
  localparam int CaseIdW = 32;
  localparam int ActW    = 6;
  localparam int CountW  = 32;
  localparam int PendW   = 16;
  localparam int RdIdxW  = 7;

  // Command codes
  localparam logic [1:0] CMD_EVENT   = 2'd0;
  localparam logic [1:0] CMD_END_LOG = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // Lifecycle codes
  localparam logic [1:0] LC_START    = 2'd1;
  localparam logic [1:0] LC_COMPLETE = 2'd2;

  localparam logic [ActW-1:0]  NumActReset = 6'd63;
  localparam logic [PendW-1:0] PendMax     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [CaseIdW-1:0] case_id;
    logic [ActW-1:0]    activity;
    logic [1:0]         lifecycle;
    logic [RdIdxW-1:0]  read_antecedent;
    logic [RdIdxW-1:0]  read_consequent;
  } lpc_in_t;

  typedef struct packed {
    logic [CountW-1:0] pair_count;
    logic              saturated;
  } lpc_out_t;

  // Operations of the pair count store
  typedef enum logic [1:0] {
    PairNop,
    PairRead,
    PairAdd,
    PairClear
  } pair_op_e;

  typedef struct packed {
    logic clearing;
    logic sat;
  } pair_stat_t;

endpackage

[rtl/lifecycle_precedence_counter.sv]
// Top level of the lifecycle precedence counter: command sequencer and pending store.
// Lifecycle precedence counter. Takes one command transfer at a time and returns
// exactly one result transfer for it. A small sequencer drives one shared
// saturating read-modify-write unit on the pair count memory. An event that
// flushes first walks the pending-complete table over its MAX_ACTIVITIES
// entries and adds the completes held in each entry to the pair memory. After
// reset, and on a clear command, the pair memory is swept to zero one entry per
// cycle over all (MAX_ACTIVITIES+1)^2 entries, 4096 by default, during which
// in_ready_o stays low. The user must write the configuration register only
// between commands, while none is in progress; the block does not enforce this.
// A finished result waits in an output register, so the next command can be
// taken while the previous result is still unclaimed.
module lifecycle_precedence_counter
  import lpc_pkg::*;
#(
  parameter int MAX_ACTIVITIES = 63,
  parameter int CASE_ID_BITS   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lpc_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpc_out_t        out_data_o,
  input  logic            cfg_we_i,
  input  logic [ActW-1:0] cfg_wdata_i
);

  localparam int Dim      = MAX_ACTIVITIES + 1;
  localparam int Cells    = Dim * Dim;
  localparam int CellW    = $clog2(Cells);
  localparam int IdxW     = $clog2(Dim + 1);
  localparam int PendIdxW = $clog2(Dim);
  localparam int CidW     = (CASE_ID_BITS < CaseIdW) ? CASE_ID_BITS : CaseIdW;

  // Sequencer state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDWAIT = 4'd1;
  localparam logic [3:0] S_CLEAR  = 4'd2;
  localparam logic [3:0] S_FSCAN  = 4'd3;
  localparam logic [3:0] S_FPEND  = 4'd4;
  localparam logic [3:0] S_FADD   = 4'd5;
  localparam logic [3:0] S_DEFER  = 4'd6;
  localparam logic [3:0] S_DADD   = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;
  localparam logic [3:0] S_INC    = 4'd9;
  localparam logic [3:0] S_RESULT = 4'd10;

  function automatic logic [CellW-1:0] pair_addr(logic [IdxW-1:0] a, logic [IdxW-1:0] b);
    logic [31:0] t;
    t = (32'(a) - 32'd1) * 32'(Dim) + (32'(b) - 32'd1);
    return t[CellW-1:0];
  endfunction

  logic [3:0]          state_q, state_d;
  lpc_in_t             item_q;
  logic [ActW-1:0]     num_act_q;
  logic [CidW-1:0]     prev_q;
  logic                have_prev_q;
  logic                start_def_q;
  logic [ActW-1:0]     def_act_q;
  logic                sat_q;
  logic                newcase_q;
  logic [IdxW-1:0]     tgt_q;
  logic [PendIdxW-1:0] a_q;
  logic [Dim-1:0]      pv_q;
  logic [PendW-1:0]    pend_mem_q [Dim];
  logic [PendW-1:0]    pend_rd_q;
  logic [CountW-1:0]   res_q;
  logic                out_valid_q;
  lpc_out_t            out_q;

  logic [IdxW-1:0]     n_eff;
  logic [IdxW-1:0]     se;
  logic                in_fire;
  logic                out_free;
  logic                act_ok;
  logic                same_case;
  logic                flush_need;
  logic                rd_ok;
  logic                a_last;
  logic [PendIdxW-1:0] act_idx;
  logic [PendW-1:0]    pend_cur;

  pair_op_e            pm_op;
  logic [CellW-1:0]    pm_addr;
  logic [PendW-1:0]    pm_amount;
  logic [CountW-1:0]   pm_rd_data;
  pair_stat_t          pm_stat;

  // Decode of the incoming command against the current log state
  always_comb begin
    n_eff      = (32'(num_act_q) > 32'(MAX_ACTIVITIES)) ? IdxW'(MAX_ACTIVITIES)
                                                        : IdxW'(num_act_q);
    se         = n_eff + IdxW'(1);
    in_fire    = in_valid_i & in_ready_o;
    out_free   = ~out_valid_q | out_ready_i;
    act_ok     = (in_data_i.activity != '0) &&
                 (32'(in_data_i.activity) <= 32'(n_eff));
    same_case  = have_prev_q && (in_data_i.case_id[CidW-1:0] == prev_q);
    flush_need = have_prev_q && (!same_case || in_data_i.lifecycle == LC_START);
    rd_ok      = (in_data_i.read_antecedent != '0) &&
                 (32'(in_data_i.read_antecedent) <= 32'(se)) &&
                 (in_data_i.read_consequent != '0) &&
                 (32'(in_data_i.read_consequent) <= 32'(se));
    a_last     = (a_q == PendIdxW'(MAX_ACTIVITIES));
    act_idx    = PendIdxW'(item_q.activity);
    pend_cur   = pv_q[act_idx] ? pend_rd_q : '0;
  end

  // Next state and requests to the pair store
  always_comb begin
    state_d   = state_q;
    pm_op     = PairNop;
    pm_addr   = '0;
    pm_amount = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.cmd)
            CMD_EVENT: begin
              if (!act_ok) begin
                state_d = S_RESULT;
              end else if (flush_need) begin
                state_d = S_FSCAN;
              end else begin
                state_d = S_DEFER;
              end
            end
            CMD_READ: begin
              if (rd_ok) begin
                pm_op   = PairRead;
                pm_addr = pair_addr(IdxW'(in_data_i.read_antecedent),
                                    IdxW'(in_data_i.read_consequent));
                state_d = S_RDWAIT;
              end else begin
                state_d = S_RESULT;
              end
            end
            CMD_CLEAR: begin
              pm_op   = PairClear;
              state_d = S_CLEAR;
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_RDWAIT: state_d = S_RESULT;
      S_CLEAR: begin
        if (!pm_stat.clearing) begin
          state_d = S_RESULT;
        end
      end
      S_FSCAN: begin
        if (pv_q[a_q]) begin
          state_d = S_FPEND;
        end else if (a_last) begin
          state_d = S_DEFER;
        end
      end
      S_FPEND: begin
        pm_op     = PairAdd;
        pm_addr   = pair_addr(IdxW'(a_q), tgt_q);
        pm_amount = pend_rd_q;
        state_d   = S_FADD;
      end
      S_FADD: state_d = a_last ? S_DEFER : S_FSCAN;
      S_DEFER: begin
        if (have_prev_q && start_def_q) begin
          pm_op     = PairAdd;
          pm_addr   = pair_addr(se, IdxW'(def_act_q));
          pm_amount = PendW'(1);
          state_d   = S_DADD;
        end else begin
          state_d = S_UPD;
        end
      end
      S_DADD: state_d = S_UPD;
      S_UPD: state_d = (item_q.lifecycle == LC_COMPLETE) ? S_INC : S_RESULT;
      S_INC: state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and log tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_act_q   <= NumActReset;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      start_def_q <= 1'b0;
      def_act_q   <= '0;
      sat_q       <= 1'b0;
      newcase_q   <= 1'b0;
      tgt_q       <= '0;
      a_q         <= '0;
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_act_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data_i.cmd)
              CMD_EVENT: begin
                newcase_q <= ~same_case;
                tgt_q     <= same_case ? IdxW'(in_data_i.activity) : se;
                a_q       <= PendIdxW'(1);
              end
              CMD_END_LOG: begin
                pv_q        <= '0;
                start_def_q <= 1'b0;
                def_act_q   <= '0;
                have_prev_q <= 1'b0;
                prev_q      <= '0;
              end
              CMD_CLEAR: begin
                pv_q        <= '0;
                start_def_q <= 1'b0;
                def_act_q   <= '0;
                have_prev_q <= 1'b0;
                prev_q      <= '0;
                sat_q       <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_FSCAN: begin
          if (!pv_q[a_q] && !a_last) begin
            a_q <= a_q + PendIdxW'(1);
          end
        end
        S_FPEND: pv_q[a_q] <= 1'b0;
        S_FADD: begin
          if (!a_last) begin
            a_q <= a_q + PendIdxW'(1);
          end
        end
        S_UPD: begin
          if (newcase_q) begin
            start_def_q <= 1'b1;
            def_act_q   <= item_q.activity;
          end else begin
            start_def_q <= 1'b0;
          end
          prev_q      <= item_q.case_id[CidW-1:0];
          have_prev_q <= 1'b1;
        end
        S_INC: begin
          if (pend_cur == PendMax) begin
            sat_q <= 1'b1;
          end else begin
            pv_q[act_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
      // Saturation reported by the pair adder
      if (pm_stat.sat) begin
        sat_q <= 1'b1;
      end
      // Output register handshake
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and the pending-complete memory
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
      res_q  <= '0;
    end
    if (state_q == S_RDWAIT) begin
      res_q <= pm_rd_data;
    end
    if (state_q == S_FSCAN) begin
      pend_rd_q <= pend_mem_q[a_q];
    end else if (state_q == S_UPD) begin
      pend_rd_q <= pend_mem_q[act_idx];
    end
    if (state_q == S_INC && pend_cur != PendMax) begin
      pend_mem_q[act_idx] <= pend_cur + PendW'(1);
    end
    if (state_q == S_RESULT && out_free) begin
      out_q.pair_count <= res_q;
      out_q.saturated  <= sat_q;
    end
  end

  lpc_pair_mem #(
    .MAX_ACTIVITIES(MAX_ACTIVITIES)
  ) u_pair_mem (
    .clk_i,
    .rst_ni,
    .op_i      (pm_op),
    .addr_i    (pm_addr),
    .amount_i  (pm_amount),
    .rd_data_o (pm_rd_data),
    .stat_o    (pm_stat)
  );

  assign in_ready_o  = (state_q == S_IDLE) && !pm_stat.clearing;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // No transfer is taken while the pair memory is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pm_stat.clearing)
    else $error("input taken during clear sweep");

  // A taken command always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("command taken without starting work");

  // A flushed pending entry is marked empty once its add is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FADD |-> !pv_q[a_q])
    else $error("pending entry still valid after flush");

  // Adder saturation shows up only in the add states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_stat.sat |-> (state_q == S_FADD || state_q == S_DADD))
    else $error("pair saturation outside an add");
`endif

endmodule

[rtl/lpc_pair_mem.sv]
// Pair count store: memory, saturating read-modify-write adder and clear sweep.
module lpc_pair_mem
  import lpc_pkg::*;
#(
  parameter int MAX_ACTIVITIES = 63,
  localparam int Dim   = MAX_ACTIVITIES + 1,
  localparam int Cells = Dim * Dim,
  localparam int CellW = $clog2(Cells)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pair_op_e          op_i,
  input  logic [CellW-1:0]  addr_i,
  input  logic [PendW-1:0]  amount_i,
  output logic [CountW-1:0] rd_data_o,
  output pair_stat_t        stat_o
);

  localparam logic [CellW-1:0] LastCell = CellW'(Cells - 1);

  logic [CountW-1:0] mem_q [Cells];
  logic [CountW-1:0] rd_data_q;
  logic              clr_busy_q;
  logic [CellW-1:0]  clr_addr_q;
  logic              add_busy_q;
  logic [CellW-1:0]  add_addr_q;
  logic [PendW-1:0]  add_amt_q;

  logic [CountW:0]   sum;
  logic [CountW-1:0] add_res;
  logic              rd_en;
  logic              wr_en;
  logic [CellW-1:0]  wr_addr;
  logic [CountW-1:0] wr_data;

  // Saturating adder on the registered read data; one write port
  always_comb begin
    rd_en   = op_i inside {PairRead, PairAdd};
    sum     = {1'b0, rd_data_q} + {{(CountW + 1 - PendW){1'b0}}, add_amt_q};
    add_res = sum[CountW] ? '1 : sum[CountW-1:0];
    wr_en   = clr_busy_q | add_busy_q;
    wr_addr = clr_busy_q ? clr_addr_q : add_addr_q;
    wr_data = clr_busy_q ? '0 : add_res;
  end

  // Memory array and read data register
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr_i];
    end
    if (op_i == PairAdd) begin
      add_addr_q <= addr_i;
      add_amt_q  <= amount_i;
    end
  end

  // Clear sweep (after reset and on request) and add tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      add_busy_q <= 1'b0;
    end else begin
      add_busy_q <= (op_i == PairAdd);
      if (op_i == PairClear) begin
        clr_busy_q <= 1'b1;
        clr_addr_q <= '0;
      end else if (clr_busy_q) begin
        if (clr_addr_q == LastCell) begin
          clr_busy_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + CellW'(1);
      end
    end
  end

  assign rd_data_o       = rd_data_q;
  assign stat_o.clearing = clr_busy_q;
  assign stat_o.sat      = add_busy_q & sum[CountW];

endmodule
